/* sv/fixed_block_free_list_allocator_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-block free-list allocator
// Property wrappers that fold away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FBFL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fbfl assertion failed");

// next-cycle implication
`define FBFL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fbfl assertion failed");

`else

`define FBFL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FBFL_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* sv/fbfl_pkg.sv */
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared constants, codes and types of the fixed-block free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fbfl_pkg;

   localparam int MAX_BLOCKS = 255;
   localparam int IDX_W      = 8;
   localparam int ADDR_W     = $clog2(MAX_BLOCKS);
   localparam int CNT_W      = 8;
   localparam int SIZE_W     = 13;
   localparam int OFF_W      = 20;
   localparam int PROD_W     = IDX_W + SIZE_W;
   localparam int ACT_W      = 2;
   localparam int STAT_W     = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = SIZE_W;

   localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(4096);

   // actions
   localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
   localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_RESET = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
   localparam logic [STAT_W-1:0] STAT_REJECTED = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BLOCKS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE = 1'b1;

   localparam logic [CNT_W-1:0]  RESET_NUM_BLOCKS = CNT_W'(255);
   localparam logic [SIZE_W-1:0] RESET_BLOCK_SIZE = SIZE_W'(16);

   // link memory access for one cycle
   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [IDX_W-1:0]  wr_data;
      logic              clear;
   } link_req_type;

endpackage

`default_nettype wire

/* sv/fbfl_ram.sv */
// ----------------------------------------------------------------------------
// fbfl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/fbfl_link.sv */
// ----------------------------------------------------------------------------
// fbfl_link
// Link memory of the free list: RAM plus one valid bit per entry; an entry
// not written since the last relink reads as its own index plus one.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fixed_block_free_list_allocator_top_macros.svh"

module fbfl_link (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire fbfl_pkg::link_req_type      link_req,
   output logic      [fbfl_pkg::IDX_W-1:0]  link_data
);
   import fbfl_pkg::*;

   logic [MAX_BLOCKS-1:0] vld_ff;
   logic [MAX_BLOCKS-1:0] vld_in;
   logic                  rd_vld_ff;
   logic [ADDR_W-1:0]     rd_addr_ff;
   logic [IDX_W-1:0]      ram_q;

   fbfl_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_BLOCKS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (link_req.wr_en),
      .wr_addr (link_req.wr_addr),
      .wr_data (link_req.wr_data),
      .rd_en   (link_req.rd_en),
      .rd_addr (link_req.rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      vld_in = vld_ff;
      if (link_req.clear) begin
         vld_in = '0;
      end else if (link_req.wr_en) begin
         vld_in[link_req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (link_req.rd_en) begin
         rd_vld_ff  <= vld_ff[link_req.rd_addr];
         rd_addr_ff <= link_req.rd_addr;
      end
   end

   assign link_data = rd_vld_ff ? ram_q : IDX_W'(rd_addr_ff) + IDX_W'(1);

   `FBFL_ASSERT_IMP(a_no_rd_wr_overlap, clock, reset,
      link_req.rd_en, !link_req.wr_en && !link_req.clear)
   `FBFL_ASSERT_IMP(a_wr_addr_in_range, clock, reset,
      link_req.wr_en, link_req.wr_addr < ADDR_W'(MAX_BLOCKS))
   `FBFL_ASSERT_IMP(a_rd_addr_in_range, clock, reset,
      link_req.rd_en, link_req.rd_addr < ADDR_W'(MAX_BLOCKS))

endmodule

`default_nettype wire

/* sv/fixed_block_free_list_allocator_top.sv */
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_top
// Fixed-block allocator over one chunk: free blocks are chained through a
// link memory; allocate pops the head, free pushes a block, reset relinks.
// ----------------------------------------------------------------------------
//  channel  direction  ports                                         transfer
//  req      in         action, block_index                           valid & ready
//  rsp      out        status, alloc_index, alloc_offset, free_count valid & ready
//  csr      in         index (0 num_blocks, 1 block_size), wdata     valid & ready
//
//  An item is taken only in idle. For an alloc, the accept cycle reads the
//  head's link from the synchronous link memory; the execute step then
//  updates head, count and memory. A relink clears per-entry valid bits at once.
//  Reset leaves the list linked in order with the full count; no sweep.
//  A result waits in the output register; the execute step stalls only
//  while that register is still full and not taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fixed_block_free_list_allocator_top_macros.svh"

module fixed_block_free_list_allocator_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [fbfl_pkg::ACT_W-1:0]       req_action,
   input  wire logic [fbfl_pkg::IDX_W-1:0]       req_block_index,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [fbfl_pkg::STAT_W-1:0]      rsp_status,
   output logic      [fbfl_pkg::IDX_W-1:0]       rsp_alloc_index,
   output logic      [fbfl_pkg::OFF_W-1:0]       rsp_alloc_offset,
   output logic      [fbfl_pkg::CNT_W-1:0]       rsp_free_count,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [fbfl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [fbfl_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fbfl_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                 state_ff, state_in;
   logic [ACT_W-1:0]     act_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     avail_ff, avail_in;
   logic [CNT_W-1:0]     num_blocks_ff;
   logic [SIZE_W-1:0]    block_size_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]    status_ff, status_in;
   logic [IDX_W-1:0]     aidx_ff, aidx_in;
   logic [OFF_W-1:0]     aoff_ff, aoff_in;
   logic [CNT_W-1:0]     fcnt_ff;

   logic                 req_xfer;
   logic                 exec_go;
   logic [CNT_W-1:0]     n_eff;
   logic [CNT_W-1:0]     n_reset_eff;
   logic [SIZE_W-1:0]    size_eff;
   logic [PROD_W-1:0]    prod;
   logic [IDX_W-1:0]     link_data;
   link_req_type         link_req;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign exec_go   = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   assign n_eff       = (num_blocks_ff > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                              : num_blocks_ff;
   assign n_reset_eff = (RESET_NUM_BLOCKS > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                                 : RESET_NUM_BLOCKS;
   assign size_eff    = (block_size_ff > MAX_SIZE) ? MAX_SIZE : block_size_ff;
   assign prod        = PROD_W'(head_ff) * PROD_W'(size_eff);

   fbfl_link u_link (
      .clock     (clock),
      .reset     (reset),
      .link_req  (link_req),
      .link_data (link_data)
   );

   // accept and execute steps: link read, decide, update list state, form the result
   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      avail_in   = avail_ff;
      status_in  = STAT_OK;
      aidx_in    = '0;
      aoff_in    = '0;

      link_req          = '0;
      link_req.rd_en    = req_xfer && (req_action == ACT_ALLOC)
                          && (head_ff < IDX_W'(MAX_BLOCKS));
      link_req.rd_addr  = head_ff[ADDR_W-1:0];
      link_req.wr_addr  = idx_ff[ADDR_W-1:0];
      link_req.wr_data  = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_IDLE;
               case (act_ff)
                  ACT_ALLOC: begin
                     if (avail_ff == '0 || head_ff >= IDX_W'(MAX_BLOCKS)) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        aidx_in  = head_ff;
                        aoff_in  = prod[OFF_W-1:0];
                        head_in  = link_data;
                        avail_in = avail_ff - CNT_W'(1);
                     end
                  end
                  ACT_FREE: begin
                     if (idx_ff >= n_eff || avail_ff >= n_eff) begin
                        status_in = STAT_REJECTED;
                     end else begin
                        link_req.wr_en = 1'b1;
                        head_in        = idx_ff;
                        avail_in       = avail_ff + CNT_W'(1);
                     end
                  end
                  ACT_RESET: begin
                     link_req.clear = 1'b1;
                     head_in        = '0;
                     avail_in       = n_eff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         avail_ff      <= n_reset_eff;
         rsp_valid_ff  <= 1'b0;
         num_blocks_ff <= RESET_NUM_BLOCKS;
         block_size_ff <= RESET_BLOCK_SIZE;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         avail_ff     <= avail_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NUM_BLOCKS: num_blocks_ff <= csr_wdata[CNT_W-1:0];
               CSR_BLOCK_SIZE: block_size_ff <= csr_wdata[SIZE_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         act_ff <= req_action;
         idx_ff <= req_block_index;
      end
      if (exec_go) begin
         status_ff <= status_in;
         aidx_ff   <= aidx_in;
         aoff_ff   <= aoff_in;
         fcnt_ff   <= avail_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_alloc_index  = aidx_ff;
   assign rsp_alloc_offset = aoff_ff;
   assign rsp_free_count   = fcnt_ff;

   `FBFL_ASSERT_NXT(a_accept_enters_exec, clock, reset,
      req_xfer, state_ff == ST_EXEC && !req_ready)
   `FBFL_ASSERT_NXT(a_list_holds_between_items, clock, reset,
      !exec_go, $stable(head_ff) && $stable(avail_ff))
   `FBFL_ASSERT_NXT(a_alloc_takes_one, clock, reset,
      exec_go && act_ff == ACT_ALLOC && status_in == STAT_OK,
      avail_ff == $past(avail_ff) - CNT_W'(1) && rsp_valid)

endmodule

`default_nettype wire
